FILE: rtl/jsd_pkg.sv
package jsd_pkg;

   // Number of cells in the sorting chain.
   localparam int MAX_RECORDS = 64;

   // Counter width that can hold the cell count itself.
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   // Sort key: the packed order gives group, then donor, then acceptor.
   typedef struct packed {
      logic [15:0] group_index;
      logic [31:0] donor_pos;
      logic [31:0] acceptor_pos;
   } jsd_key_type;

   // One cell slot or one record moving along the chain.
   typedef struct packed {
      logic        valid;
      jsd_key_type key;
   } jsd_slot_type;

   // Input item.
   typedef struct packed {
      logic [15:0] group_index;
      logic [31:0] donor_pos;
      logic [31:0] acceptor_pos;
      logic        final_record;
   } jsd_req_type;

   // Result item.
   typedef struct packed {
      logic [15:0] out_group;
      logic [31:0] out_donor;
      logic [31:0] out_acceptor;
      logic        run_end;
      logic        overflowed;
   } jsd_rsp_type;

   // Control states of the block.
   typedef enum logic [2:0] {
      ST_FILL   = 3'b001,
      ST_SETTLE = 3'b010,
      ST_DRAIN  = 3'b100
   } jsd_state_type;

endpackage

FILE: rtl/jsd_cell.sv
module jsd_cell
   import jsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  jsd_slot_type ins_in,
   output jsd_slot_type ins_out,
   input  jsd_slot_type next_slot,
   output jsd_slot_type slot
);

   jsd_slot_type stored_ff;
   jsd_slot_type stored_in;
   jsd_slot_type pass_ff;
   jsd_slot_type pass_in;

   // Insertion keeps the smaller key here and hands the larger one on.
   // During the drain every cell takes the slot of its upper neighbor.
   always_comb begin
      stored_in = stored_ff;
      pass_in   = '0;
      if (shift_en) begin
         stored_in = next_slot;
      end else if (ins_in.valid) begin
         if (!stored_ff.valid) begin
            stored_in = ins_in;
         end else if (ins_in.key < stored_ff.key) begin
            stored_in = ins_in;
            pass_in   = stored_ff;
         end else begin
            pass_in = ins_in;
         end
      end
   end

   // Valid bits are cleared by reset; the keys need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '{valid: 1'b0, key: stored_in.key};
         pass_ff   <= '{valid: 1'b0, key: pass_in.key};
      end else begin
         stored_ff <= stored_in;
         pass_ff   <= pass_in;
      end
   end

   assign ins_out = pass_ff;
   assign slot    = stored_ff;

endmodule

FILE: rtl/junction_sort_dedupe.sv
// Sorts a set of junction records and removes duplicates.
// Input channel req_: one record per item, accepted when req_valid and
// req_ready are high. The item with final_record set closes the set.
// Records are inserted into a chain of MAX_RECORDS cells, one per cycle,
// so a set is taken in at one item per cycle. Records beyond capacity are
// dropped and every result of that set carries overflowed.
// After the closing item the chain settles while a record still walks to its
// cell; req_ready is low from then until the last record has left the chain.
// Result channel rsp_: the chain shifts toward cell 0 one cell per cycle;
// cell 0 is compared with cell 1, and a record is sent only when it
// differs from its successor, so each distinct junction appears once and
// run_end marks the last one. When the receiver holds rsp_ready low, the
// result register holds and the chain stops at the next record to send
// until the item is taken.
// Reset (synchronous, active high) empties the chain and the result
// register and opens a new set.
module junction_sort_dedupe
   import jsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  jsd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output jsd_rsp_type rsp_data
);

   jsd_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] wait_ff, wait_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   jsd_rsp_type rsp_data_ff, rsp_data_in;

   jsd_slot_type ins_chain [MAX_RECORDS+1];
   jsd_slot_type slots [MAX_RECORDS+1];

   logic accept;
   logic has_room;
   logic out_free;
   logic is_last;
   logic emit_need;
   logic shift_en;

   assign req_ready = (state_ff == ST_FILL);
   assign accept    = req_valid && req_ready;
   assign has_room  = (count_ff < CNT_W'(MAX_RECORDS));

   // A new record enters cell 0 when there is room for it.
   assign ins_chain[0] = {accept && has_room, req_data.group_index,
                          req_data.donor_pos, req_data.acceptor_pos};

   assign slots[MAX_RECORDS] = '0;

   // The chain of cells.
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      jsd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .ins_in    (ins_chain[i]),
         .ins_out   (ins_chain[i+1]),
         .next_slot (slots[i+1]),
         .slot      (slots[i])
      );
   end

   // Drain: emit cell 0 only when it differs from cell 1 or is the last.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = !slots[1].valid;
   assign emit_need = is_last || (slots[0].key != slots[1].key);
   assign shift_en  = (state_ff == ST_DRAIN) && slots[0].valid
                      && (!emit_need || out_free);

   // Set collection, settling and drain control.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      wait_in    = wait_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.final_record) begin
                  state_in = ST_SETTLE;
                  wait_in  = '0;
               end
            end
         end
         ST_SETTLE: begin
            wait_in = wait_ff + CNT_W'(1);
            if (wait_ff == CNT_W'(MAX_RECORDS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!slots[0].valid) begin
               state_in   = ST_FILL;
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (shift_en && emit_need) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.out_group    = slots[0].key.group_index;
         rsp_data_in.out_donor    = slots[0].key.donor_pos;
         rsp_data_in.out_acceptor = slots[0].key.acceptor_pos;
         rsp_data_in.run_end      = is_last;
         rsp_data_in.overflowed   = dropped_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         wait_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
